/* hdl/mprd_pkg.sv */
// ----------------------------------------------------------------------------
// mprd_pkg
// Shared types and constants for the motor PWM ramp driver.
// ----------------------------------------------------------------------------
package mprd_pkg;

	typedef enum logic [1:0] {
		CMD_FWD    = 2'd0,
		CMD_BWD    = 2'd1,
		CMD_STOP   = 2'd2,
		CMD_SIGNED = 2'd3
	} cmd_e_t;

	// configuration register indexes
	localparam int unsigned CFG_ADDR_BITS = 3;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_OUT_MIN    = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_OUT_MAX    = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_RAMP_STEP  = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_SAMPLE_MS  = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_INVERT_DIR = 3'd4;
	localparam int unsigned CFG_DATA_BITS = 16;

	// saturation width for stop and signed drive duty
	localparam int unsigned DUTY_BITS = 8;

	localparam int unsigned IN_DATA_BITS  = 72;
	localparam int unsigned IN_USER_BITS  = 2;
	localparam int unsigned OUT_DATA_BITS = 24;

	typedef struct packed {
		logic [7:0]  out_min;
		logic [7:0]  out_max;
		logic [7:0]  ramp_step;
		logic [15:0] sample_ms;
		logic        invert_dir;
	} cfg_t;

	typedef struct packed {
		cmd_e_t             command;
		logic signed [8:0]  target;
		logic               ramp_enable;
		logic               use_trim;
		logic [7:0]         step_override;
		logic [31:0]        now_ms;
		logic signed [18:0] trim_prod;
	} item_t;

	typedef struct packed {
		logic [7:0]        duty;
		logic              direction;
		logic              direction_driven;
		logic signed [8:0] level;
	} result_t;

endpackage

/* hdl/mprd_in_stage.sv */
// ----------------------------------------------------------------------------
// mprd_in_stage
// Input register: unpacks an item and forms the trim product.
// ----------------------------------------------------------------------------
module mprd_in_stage (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mprd_pkg::IN_DATA_BITS-1:0]    s_tdata,
	input  logic [mprd_pkg::IN_USER_BITS-1:0]    s_tuser,
	input  logic                                 take,
	output logic                                 valid_s1,
	output mprd_pkg::item_t                      item_s1
);

	logic signed [7:0]  gain;
	logic signed [10:0] err;
	mprd_pkg::item_t    item_d;

	assign s_tready = !valid_s1 || take;

	always_comb begin
		gain                 = s_tdata[18:11];
		err                  = s_tdata[29:19];
		item_d.command       = mprd_pkg::cmd_e_t'(s_tuser);
		item_d.target        = s_tdata[8:0];
		item_d.ramp_enable   = s_tdata[9];
		item_d.use_trim      = s_tdata[10];
		item_d.step_override = s_tdata[37:30];
		item_d.now_ms        = s_tdata[69:38];
		item_d.trim_prod     = 19'(gain) * 19'(err);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* hdl/mprd_core.sv */
// ----------------------------------------------------------------------------
// mprd_core
// Ramp state and per-item level, clamp and duty computation.
// ----------------------------------------------------------------------------
module mprd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  mprd_pkg::cfg_t      cfg,
	input  logic                valid_s1,
	input  mprd_pkg::item_t     item_s1,
	input  logic                out_ready,
	output logic                take,
	output mprd_pkg::result_t   result
);

	localparam logic [31:0] DUTY_MAX = 32'((64'd1 << mprd_pkg::DUTY_BITS) - 64'd1);

	logic signed [9:0]  ulvl_q;
	logic signed [9:0]  slvl_q;
	logic [31:0]        last_q;

	logic               is_signed;
	logic               is_stop;
	logic [7:0]         step;
	logic signed [10:0] stp11;
	logic signed [10:0] cur11;
	logic signed [10:0] set11;
	logic signed [9:0]  cur;
	logic signed [9:0]  set;
	logic [31:0]        elapsed;
	logic               due;
	logic               want_ramp;
	logic signed [10:0] moved;
	logic signed [9:0]  ramped;
	logic signed [9:0]  new_lvl;
	logic signed [19:0] trim_sum;
	logic signed [19:0] lim_lo;
	logic signed [19:0] lim_hi;
	logic signed [19:0] clamp_in;
	logic signed [19:0] clamp_out;
	logic [9:0]         mag;
	logic [7:0]         duty;
	logic               dir;
	logic               driven;
	logic [31:0]        last_d;

	assign take = valid_s1 && out_ready;

	always_comb begin
		is_signed = item_s1.command == mprd_pkg::CMD_SIGNED;
		is_stop   = item_s1.command == mprd_pkg::CMD_STOP;
		step      = (item_s1.step_override != 8'd0) ? item_s1.step_override : cfg.ramp_step;
		stp11     = signed'({3'b000, step});
		cur       = is_signed ? slvl_q : ulvl_q;
		set       = is_stop ? 10'sd0 : 10'(item_s1.target);
		cur11     = 11'(cur);
		set11     = 11'(set);
		elapsed   = item_s1.now_ms - last_q;
		due       = elapsed >= {16'd0, cfg.sample_ms};
		want_ramp = item_s1.ramp_enable && (cur != set);
		last_d    = last_q;

		// one step toward the target, snapping when within a step
		if ((set11 - stp11 <= cur11) && (cur11 <= set11 + stp11)) begin
			moved = set11;
		end else if (cur11 < set11) begin
			moved = cur11 + stp11;
		end else begin
			moved = cur11 - stp11;
		end

		if (want_ramp) begin
			if (due) begin
				ramped = moved[9:0];
				last_d = item_s1.now_ms;
			end else begin
				ramped = cur;
			end
		end else begin
			ramped = set;
		end

		// forward/backward clamp; low limit tested first
		trim_sum = 20'(ramped) + 20'(item_s1.trim_prod);
		lim_lo   = signed'({12'd0, cfg.out_min});
		lim_hi   = signed'({12'd0, cfg.out_max});
		clamp_in = item_s1.use_trim ? trim_sum : 20'(ramped);
		if (clamp_in < lim_lo) begin
			clamp_out = lim_lo;
		end else if (clamp_in > lim_hi) begin
			clamp_out = lim_hi;
		end else begin
			clamp_out = clamp_in;
		end

		mag     = ramped[9] ? 10'(-ramped) : 10'(ramped);
		new_lvl = ramped;
		duty    = 8'd0;
		dir     = 1'b0;
		driven  = 1'b0;

		case (item_s1.command)
			mprd_pkg::CMD_FWD, mprd_pkg::CMD_BWD: begin
				if (!item_s1.use_trim) begin
					new_lvl = clamp_out[9:0];
				end
				duty   = clamp_out[7:0];
				dir    = (item_s1.command == mprd_pkg::CMD_FWD) ? cfg.invert_dir
					: !cfg.invert_dir;
				driven = 1'b1;
			end
			mprd_pkg::CMD_STOP: begin
				if (ramped[9]) begin
					duty = 8'd0;
				end else if ({22'd0, mag} > DUTY_MAX) begin
					duty = DUTY_MAX[7:0];
				end else begin
					duty = mag[7:0];
				end
			end
			mprd_pkg::CMD_SIGNED: begin
				duty   = ({22'd0, mag} > DUTY_MAX) ? DUTY_MAX[7:0] : mag[7:0];
				dir    = ramped[9] ? !cfg.invert_dir : cfg.invert_dir;
				driven = 1'b1;
			end
			default: begin
				duty = 8'd0;
			end
		endcase

		result.duty             = duty;
		result.direction        = dir;
		result.direction_driven = driven;
		result.level            = new_lvl[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ulvl_q <= '0;
			slvl_q <= '0;
			last_q <= '0;
		end else if (take) begin
			if (is_signed) begin
				slvl_q <= new_lvl;
			end else begin
				ulvl_q <= new_lvl;
			end
			last_q <= last_d;
		end
	end

	// state moves only when an item is consumed
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(ulvl_q) && $stable(slvl_q) && $stable(last_q))
		else $error("ramp state changed with no item");

	// step time is only touched by a ramping item
	a_time_ramp_only: assert property (@(posedge clk) disable iff (!arst_n)
		take && !item_s1.ramp_enable |=> $stable(last_q))
		else $error("step time moved without ramping");

	// levels never leave the target range
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		ulvl_q >= -10'sd256 && ulvl_q <= 10'sd255 &&
		slvl_q >= -10'sd256 && slvl_q <= 10'sd255)
		else $error("ramp level out of range");

endmodule

/* hdl/mprd_out_stage.sv */
// ----------------------------------------------------------------------------
// mprd_out_stage
// Result register and packing onto the master stream.
// ----------------------------------------------------------------------------
module mprd_out_stage (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  mprd_pkg::result_t                     result,
	output logic                                  out_ready,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mprd_pkg::OUT_DATA_BITS-1:0]    m_tdata
);

	mprd_pkg::result_t res_q;

	assign out_ready = !m_tvalid || m_tready;
	assign m_tdata   = {5'd0, res_q.level, res_q.direction_driven, res_q.direction,
		res_q.duty};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ready) begin
			m_tvalid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && in_valid) begin
			res_q <= result;
		end
	end

endmodule

/* hdl/motor_pwm_ramp_driver_unit.sv */
// ----------------------------------------------------------------------------
// motor_pwm_ramp_driver_unit
// Motor PWM drive with soft start and slew-rate limited ramping.
// ----------------------------------------------------------------------------
//  channel  | signals                        | carries
//  ---------+--------------------------------+--------------------------------
//  s_*      | s_tvalid s_tready s_tdata s_tuser | command item in
//  m_*      | m_tvalid m_tready m_tdata      | duty / direction / level out
//  cfg_*    | cfg_we cfg_addr cfg_wdata      | register writes, no read-back
//
//  One item per cycle sustained while m_tready is high; an item passes the
//  input register, then level/clamp logic into the result register.
//  The level and step-time feedback closes inside the core, through its registers.
//  A held result stalls the input register only when both are full.
//  arst_n clears levels, step time, valid flags and loads register defaults.
// ----------------------------------------------------------------------------
module motor_pwm_ramp_driver_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// target[8:0] ramp_enable[9] use_trim[10] trim_gain[18:11]
	// trim_error[29:19] step_override[37:30] now_ms[69:38], zero pad
	input  logic [mprd_pkg::IN_DATA_BITS-1:0]      s_tdata,
	// command[1:0]
	input  logic [mprd_pkg::IN_USER_BITS-1:0]      s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// duty[7:0] direction[8] direction_driven[9] level[18:10], zero pad
	output logic [mprd_pkg::OUT_DATA_BITS-1:0]     m_tdata,
	input  logic                                   cfg_we,
	input  logic [mprd_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
	input  logic [mprd_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

	mprd_pkg::cfg_t    cfg_q;
	mprd_pkg::item_t   item_s1;
	mprd_pkg::result_t result;
	logic              valid_s1;
	logic              take;
	logic              out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_min    <= 8'd0;
			cfg_q.out_max    <= 8'd255;
			cfg_q.ramp_step  <= 8'd7;
			cfg_q.sample_ms  <= 16'd30;
			cfg_q.invert_dir <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				mprd_pkg::CFG_OUT_MIN:    cfg_q.out_min    <= cfg_wdata[7:0];
				mprd_pkg::CFG_OUT_MAX:    cfg_q.out_max    <= cfg_wdata[7:0];
				mprd_pkg::CFG_RAMP_STEP:  cfg_q.ramp_step  <= cfg_wdata[7:0];
				mprd_pkg::CFG_SAMPLE_MS:  cfg_q.sample_ms  <= cfg_wdata;
				mprd_pkg::CFG_INVERT_DIR: cfg_q.invert_dir <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	mprd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mprd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_ready (out_ready),
		.take      (take),
		.result    (result)
	);

	mprd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.result    (result),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

/* tb/motor_pwm_ramp_driver_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_pwm_ramp_driver_unit_tb
// Self-checking bench for the motor PWM ramp driver. It walks a table of
// directed commands, then runs ramp sequences under several register
// settings. Both stream sides see random gaps. Every result is checked
// against an in-bench model of the ramp, clamp and trim, or a typed table row.
// ----------------------------------------------------------------------------
module motor_pwm_ramp_driver_unit_tb;
	import mprd_pkg::*;

	localparam int DUTY_MAX    = (1 << mprd_pkg::DUTY_BITS) - 1;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 200;

	typedef struct {
		cmd_e_t            command;
		logic signed [8:0] target;
		logic              ramp_en;
		logic              trim_en;
		logic signed [7:0] gain;
		logic signed [10:0] err;
		logic [7:0]        step_ovr;
		logic [31:0]       now_ms;
	} drive_cmd_t;

	typedef struct {
		bit         is_cfg;
		cfg_t       cfg;
		drive_cmd_t cmd;
		bit         typed;
		result_t    want;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic [IN_USER_BITS-1:0]  s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     cfg_we;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	// model of the block
	cfg_t        cur_cfg;
	int          mag_level;
	int          sgn_level;
	logic [31:0] last_step_ms;

	result_t     pending_drive[$];
	dir_row_t    dir_tab[$];
	int          mismatches;
	bit          rx_hold_req;
	logic [31:0] sim_ms;

	motor_pwm_ramp_driver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int clip(int x, int lo, int hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	// one slew step toward set, only once the sample interval has passed
	function automatic int ramp_toward(int lvl, int set, int step, logic [31:0] now);
		logic [31:0] elapsed;
		elapsed = now - last_step_ms;
		if (elapsed >= {16'h0, cur_cfg.sample_ms} && lvl != set) begin
			if (set - step <= lvl && lvl <= set + step)
				lvl = set;
			else if (lvl < set)
				lvl = lvl + step;
			else
				lvl = lvl - step;
			last_step_ms = now;
		end
		return lvl;
	endfunction

	function automatic result_t compute_drive(drive_cmd_t c);
		int      tgt;
		int      step;
		int      duty;
		int      lvl;
		result_t r;
		tgt = c.target;
		step = (c.step_ovr != 8'd0) ? int'(c.step_ovr) : int'(cur_cfg.ramp_step);
		r = '0;
		case (c.command)
			CMD_SIGNED: begin
				if (c.ramp_en && sgn_level != tgt)
					sgn_level = ramp_toward(sgn_level, tgt, step, c.now_ms);
				else
					sgn_level = tgt;
				lvl = sgn_level;
				duty = (lvl < 0) ? -lvl : lvl;
				if (duty > DUTY_MAX)
					duty = DUTY_MAX;
				r.direction = (lvl < 0) ? ~cur_cfg.invert_dir : cur_cfg.invert_dir;
				r.direction_driven = 1'b1;
			end
			CMD_STOP: begin
				if (c.ramp_en && mag_level != 0)
					mag_level = ramp_toward(mag_level, 0, step, c.now_ms);
				else
					mag_level = 0;
				lvl = mag_level;
				duty = clip(lvl, 0, DUTY_MAX);
			end
			default: begin
				if (c.ramp_en && mag_level != tgt)
					mag_level = ramp_toward(mag_level, tgt, step, c.now_ms);
				else
					mag_level = tgt;
				// with trim the level keeps its unclamped value
				if (c.trim_en) begin
					duty = clip(mag_level + int'(c.gain) * int'(c.err),
						int'(cur_cfg.out_min), int'(cur_cfg.out_max));
				end else begin
					mag_level = clip(mag_level, int'(cur_cfg.out_min), int'(cur_cfg.out_max));
					duty = mag_level;
				end
				lvl = mag_level;
				r.direction = (c.command == CMD_FWD) ? cur_cfg.invert_dir : ~cur_cfg.invert_dir;
				r.direction_driven = 1'b1;
			end
		endcase
		r.duty = duty[7:0];
		r.level = lvl[8:0];
		return r;
	endfunction

	function automatic logic [31:0] advance_ms();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			sim_ms = sim_ms + $urandom_range(0, 2 * cur_cfg.sample_ms + 2);
		else if (r < 65)
			sim_ms = sim_ms + cur_cfg.sample_ms;
		else if (r < 75)
			sim_ms = sim_ms + cur_cfg.sample_ms - 32'd1;
		else if (r < 90)
			sim_ms = sim_ms;
		else if (r < 95)
			sim_ms = $urandom;
		else
			sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
		return sim_ms;
	endfunction

	function automatic drive_cmd_t rand_drive(cmd_e_t cmd, int tgt, bit ramp, bit trim);
		drive_cmd_t c;
		int         r;
		c.command = cmd;
		c.target = 9'(tgt);
		c.ramp_en = ramp;
		c.trim_en = trim;
		if ($urandom_range(0, 9) < 7) begin
			c.gain = 8'($urandom_range(0, 255));
			c.err = 11'($urandom_range(0, 2047));
		end else begin
			c.gain = 8'($urandom_range(0, 6) - 3);
			c.err = 11'($urandom_range(0, 20) - 10);
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			c.step_ovr = 8'd0;
		else if (r < 80)
			c.step_ovr = 8'($urandom_range(1, 16));
		else
			c.step_ovr = 8'($urandom_range(1, 255));
		c.now_ms = advance_ms();
		return c;
	endfunction

	function automatic int rand_target();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 255;
		if (r == 1)
			return -255;
		if (r == 2)
			return 0;
		return $urandom_range(0, 510) - 255;
	endfunction

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic cfg_t phase_cfg(int p);
		cfg_t c;
		case (p)
			0: c = '{8'd0, 8'd255, 8'd1, 16'd0, 1'b0};
			1: c = '{8'd255, 8'd0, 8'd255, 16'hFFFF, 1'b1};
			2: c = '{8'd0, 8'd255, 8'd7, 16'd30, 1'b1};
			3: c = '{8'd10, 8'd240, 8'd0, 16'd3, 1'b0};
			default: begin
				c.out_min = 8'($urandom_range(0, 128));
				if ($urandom_range(0, 99) < 15)
					c.out_max = 8'($urandom_range(0, c.out_min));
				else
					c.out_max = 8'($urandom_range(c.out_min, 255));
				if ($urandom_range(0, 1) == 0)
					c.ramp_step = 8'($urandom_range(1, 16));
				else
					c.ramp_step = 8'($urandom_range(1, 255));
				case ($urandom_range(0, 9))
					0: c.sample_ms = 16'($urandom_range(65000, 65535));
					1, 2: c.sample_ms = 16'($urandom_range(61, 2000));
					default: c.sample_ms = 16'($urandom_range(0, 60));
				endcase
				c.invert_dir = 1'($urandom_range(0, 1));
			end
		endcase
		return c;
	endfunction

	// table row: command, target, ramp, trim, gain, error, step override, time,
	// then a typed expectation where one is given
	task automatic add_row(cmd_e_t cmd, int tgt, bit ramp, bit trim, int gain, int err,
		int ovr, int unsigned now, bit typed, int duty, bit dir, bit drv, int lvl);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.cfg = '0;
		row.cmd.command = cmd;
		row.cmd.target = 9'(tgt);
		row.cmd.ramp_en = ramp;
		row.cmd.trim_en = trim;
		row.cmd.gain = 8'(gain);
		row.cmd.err = 11'(err);
		row.cmd.step_ovr = 8'(ovr);
		row.cmd.now_ms = now;
		row.typed = typed;
		row.want.duty = 8'(duty);
		row.want.direction = dir;
		row.want.direction_driven = drv;
		row.want.level = 9'(lvl);
		dir_tab.push_back(row);
	endtask

	task automatic add_cfg_row(cfg_t c);
		dir_row_t row;
		row = dir_tab[0];
		row.is_cfg = 1'b1;
		row.cfg = c;
		dir_tab.push_back(row);
	endtask

	// all tasks below are entered just after a falling edge
	task automatic hold_input(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_drive(drive_cmd_t c, bit typed, result_t want);
		result_t r;
		s_tdata <= {2'b00, c.now_ms, c.step_ovr, c.err, c.gain, c.trim_en, c.ramp_en, c.target};
		s_tuser <= c.command;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		r = compute_drive(c);
		pending_drive.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_drive.size() != 0 && guard < 50000) begin
			@(negedge clk);
			guard++;
		end
		if (pending_drive.size() != 0) begin
			mismatches++;
			$display("%0d drive results never arrived", pending_drive.size());
			pending_drive.delete();
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic load_settings(cfg_t c);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_OUT_MIN;
		cfg_wdata <= {8'h00, c.out_min};
		@(negedge clk);
		cfg_addr <= CFG_OUT_MAX;
		cfg_wdata <= {8'h00, c.out_max};
		@(negedge clk);
		cfg_addr <= CFG_RAMP_STEP;
		cfg_wdata <= {8'h00, c.ramp_step};
		@(negedge clk);
		cfg_addr <= CFG_SAMPLE_MS;
		cfg_wdata <= c.sample_ms;
		@(negedge clk);
		cfg_addr <= CFG_INVERT_DIR;
		cfg_wdata <= {15'h0, c.invert_dir};
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int rdy_left;
		int r;
		m_tready = 1'b0;
		rdy_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rdy_left = 0;
			end else begin
				if (rdy_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 65) begin
						m_tready <= 1'b1;
						rdy_left = $urandom_range(1, 20);
					end else if (r < 72) begin
						m_tready <= 1'b1;
						rdy_left = $urandom_range(50, 150);
					end else if (r < 95) begin
						m_tready <= 1'b0;
						rdy_left = $urandom_range(1, 3);
					end else begin
						m_tready <= 1'b0;
						rdy_left = $urandom_range(10, 60);
					end
				end
				rdy_left--;
			end
		end
	end

	always @(posedge clk) begin : check_drive
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.duty = m_tdata[7:0];
			got.direction = m_tdata[8];
			got.direction_driven = m_tdata[9];
			got.level = m_tdata[18:10];
			if (pending_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected drive result: duty %0d dir %0b driven %0b level %0d",
						got.duty, got.direction, got.direction_driven, got.level);
			end else begin
				want = pending_drive.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"drive mismatch: expected duty %0d dir %0b driven %0b level %0d,",
							" got duty %0d dir %0b driven %0b level %0d"},
							want.duty, want.direction, want.direction_driven, want.level,
							got.duty, got.direction, got.direction_driven, got.level);
				end
			end
		end
	end

	initial begin
		drive_cmd_t c;
		cmd_e_t     cmd;
		result_t    none;
		int         phase;
		int         sent;
		int         seq_len;
		int         tgt;
		int         k;
		bit         burst;
		bit         ramp;
		bit         trim;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		rx_hold_req = 1'b0;
		mismatches = 0;
		none = '0;
		sim_ms = '0;
		cur_cfg = '{8'd0, 8'd255, 8'd7, 16'd30, 1'b1};
		mag_level = 0;
		sgn_level = 0;
		last_step_ms = '0;

		// defaults: limits 0..255, step 7, interval 30 ms, forward line high
		add_row(CMD_FWD, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 0);
		add_row(CMD_FWD, 255, 0, 0, 0, 0, 0, 0, 1, 255, 1, 1, 255);
		add_row(CMD_BWD, -255, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0);
		add_row(CMD_BWD, 100, 0, 0, 0, 0, 0, 0, 1, 100, 0, 1, 100);
		add_row(CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(CMD_SIGNED, -255, 0, 0, 0, 0, 0, 0, 1, 255, 0, 1, -255);
		add_row(CMD_SIGNED, 255, 0, 0, 0, 0, 0, 0, 1, 255, 1, 1, 255);
		// trim saturates both ways, level stays at the target
		add_row(CMD_FWD, 0, 0, 1, -128, -1024, 0, 0, 1, 255, 1, 1, 0);
		add_row(CMD_FWD, 255, 0, 1, -128, 1023, 0, 0, 1, 0, 1, 1, 255);
		// stop ramp: one ms short, on the interval, then snap with a wide override
		add_row(CMD_STOP, 0, 1, 0, 0, 0, 0, 29, 0, 0, 0, 0, 0);
		add_row(CMD_STOP, 0, 1, 0, 0, 0, 0, 30, 0, 0, 0, 0, 0);
		add_row(CMD_STOP, 0, 1, 0, 0, 0, 250, 60, 0, 0, 0, 0, 0);
		add_row(CMD_FWD, 100, 1, 0, 0, 0, 0, 60, 0, 0, 0, 0, 0);
		add_row(CMD_FWD, 100, 1, 0, 0, 0, 255, 90, 0, 0, 0, 0, 0);
		// signed ramp across the 32-bit time wrap
		add_row(CMD_SIGNED, -255, 1, 0, 0, 0, 100, 32'hFFFF_FFF0, 0, 0, 0, 0, 0);
		add_row(CMD_SIGNED, -255, 1, 0, 0, 0, 0, 32'h0000_000E, 0, 0, 0, 0, 0);
		add_row(CMD_SIGNED, -255, 1, 0, 0, 0, 0, 32'h0000_000F, 0, 0, 0, 0, 0);
		// zero step, no interval, limits crossed, forward line low
		add_cfg_row('{8'd200, 8'd50, 8'd0, 16'd0, 1'b0});
		add_row(CMD_FWD, 0, 1, 0, 0, 0, 0, 100, 0, 0, 0, 0, 0);
		add_row(CMD_FWD, 120, 0, 0, 0, 0, 0, 100, 1, 200, 0, 1, 200);
		add_row(CMD_BWD, 255, 0, 0, 0, 0, 0, 100, 1, 50, 1, 1, 50);
		add_row(CMD_FWD, 0, 0, 1, 1, 10, 0, 101, 0, 0, 0, 0, 0);
		add_row(CMD_SIGNED, -255, 1, 0, 0, 0, 0, 5, 0, 0, 0, 0, 0);
		add_row(CMD_SIGNED, 255, 1, 0, 0, 0, 3, 5, 0, 0, 0, 0, 0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				drain_results();
				load_settings(dir_tab[i].cfg);
			end else begin
				hold_input(rand_gap());
				send_drive(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			load_settings(phase_cfg(phase));
			sent = 0;
			if (phase == 2) begin
				// output held off while items keep coming, so the input stalls
				rx_hold_req = 1'b1;
				for (k = 0; k < 40; k++)
					send_drive(rand_drive(cmd_e_t'($urandom_range(0, 3)), rand_target(),
						1'b1, 1'($urandom_range(0, 1))), 1'b0, none);
				sent = 40;
			end
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 85) begin
					// well-formed ramp: same command and target for a while
					cmd = cmd_e_t'($urandom_range(0, 3));
					tgt = rand_target();
					trim = ($urandom_range(0, 99) < 30);
					burst = ($urandom_range(0, 99) < 30);
					seq_len = $urandom_range(2, 24);
					for (k = 0; k < seq_len; k++) begin
						ramp = ($urandom_range(0, 9) != 0);
						c = rand_drive(cmd, tgt, ramp, trim);
						hold_input(burst ? 0 : rand_gap());
						send_drive(c, 1'b0, none);
					end
					sent += seq_len;
				end else begin
					c = rand_drive(cmd_e_t'($urandom_range(0, 3)),
						$urandom_range(0, 510) - 255, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					if ($urandom_range(0, 1) == 0)
						c.now_ms = $urandom;
					hold_input(rand_gap());
					send_drive(c, 1'b0, none);
					sent++;
				end
				if ($urandom_range(0, 99) < 3)
					drain_results();
			end
		end

		drain_results();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/mprd_pkg.sv
hdl/mprd_in_stage.sv
hdl/mprd_core.sv
hdl/mprd_out_stage.sv
hdl/motor_pwm_ramp_driver_unit.sv
tb/motor_pwm_ramp_driver_unit_tb.sv
